[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Each check is compiled in simulation and left empty for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a consequent follows its antecedent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/mrf_pkg.sv]
package mrf_pkg;

   // Fixed field widths
   localparam int REQ_TYPE_W = 2;
   localparam int INDEX_W    = 3;
   localparam int STATUS_W   = 2;
   localparam int LOST_W     = 32;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_INIT  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERWRITE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

   localparam logic [LOST_W-1:0] LOST_MAX = '1;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the request beat
      logic execute;   // update pointers, access the memory
      logic reply;     // load the result register
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic slot_free; // result register empty or being drained
   } dp_status_type;

endpackage

[rtl/mrf_if.sv]
interface mrf_req_if #(parameter int DATA_WIDTH = 32);
   import mrf_pkg::*;

   logic                           valid;
   logic                           ready;
   logic [REQ_TYPE_W-1:0]          req_type;
   logic [INDEX_W-1:0]             fifo_index;
   logic signed [DATA_WIDTH-1:0]   write_data;

   modport source (output valid, output req_type, output fifo_index,
                   output write_data, input ready);
   modport sink   (input valid, input req_type, input fifo_index,
                   input write_data, output ready);
endinterface

interface mrf_rsp_if #(parameter int DATA_WIDTH = 32);
   import mrf_pkg::*;

   logic                           valid;
   logic                           ready;
   logic signed [DATA_WIDTH-1:0]   read_data;
   logic [STATUS_W-1:0]            status;
   logic [LOST_W-1:0]              lost_count;

   modport source (output valid, output read_data, output status,
                   output lost_count, input ready);
   modport sink   (input valid, input read_data, input status,
                   input lost_count, output ready);
endinterface

[rtl/mrf_ctrl.sv]
module mrf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mrf_pkg::dp_status_type dp_status,
   output mrf_pkg::ctl_cmd_type   cmd
);
   import mrf_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_ACCESS = 2'd1;
   localparam logic [1:0] S_REPLY  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Sequence one request: accept, access, reply
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      case (state_ff)
         S_IDLE: begin
            // hold off request beats while reset is asserted
            req_ready   = !reset;
            cmd.capture = req_valid && !reset;
            if (req_valid) begin
               state_in = S_ACCESS;
            end
         end
         S_ACCESS: begin
            cmd.execute = 1'b1;
            state_in    = S_REPLY;
         end
         S_REPLY: begin
            if (dp_status.slot_free) begin
               cmd.reply = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/mrf_datapath.sv]
module mrf_datapath #(
   parameter int FIFO_DEPTH = 16,
   parameter int NUM_FIFOS  = 4,
   parameter int DATA_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mrf_pkg::ctl_cmd_type             cmd,
   output mrf_pkg::dp_status_type           dp_status,
   input  logic [mrf_pkg::REQ_TYPE_W-1:0]   req_type,
   input  logic [mrf_pkg::INDEX_W-1:0]      fifo_index,
   input  logic signed [DATA_WIDTH-1:0]     write_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [DATA_WIDTH-1:0]     read_data,
   output logic [mrf_pkg::STATUS_W-1:0]     status,
   output logic [mrf_pkg::LOST_W-1:0]       lost_count
);
   import mrf_pkg::*;

   localparam int PTR_W     = $clog2(FIFO_DEPTH);
   localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
   localparam int IDX_W     = (NUM_FIFOS > 1) ? $clog2(NUM_FIFOS) : 1;
   localparam int MEM_DEPTH = NUM_FIFOS * FIFO_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   // Request register
   logic [REQ_TYPE_W-1:0]        type_ff;
   logic [INDEX_W-1:0]           idx_ff;
   logic [DATA_WIDTH-1:0]        data_ff;

   // Per-FIFO control state
   logic [PTR_W-1:0]             head_ff [NUM_FIFOS];
   logic [PTR_W-1:0]             tail_ff [NUM_FIFOS];
   logic [CNT_W-1:0]             fill_ff [NUM_FIFOS];
   logic [LOST_W-1:0]            lost_ff [NUM_FIFOS];

   // Entry storage
   logic [DATA_WIDTH-1:0]        entry_store_ff [MEM_DEPTH];
   logic [DATA_WIDTH-1:0]        rdata_ff;

   // Pending result
   logic                         read_ok_ff;
   logic [STATUS_W-1:0]          status_res_ff;
   logic [LOST_W-1:0]            lost_res_ff;

   // Result register
   logic                         rsp_valid_ff;
   logic [DATA_WIDTH-1:0]        read_data_ff;
   logic [STATUS_W-1:0]          status_ff;
   logic [LOST_W-1:0]            lost_count_ff;

   logic [IDX_W-1:0]             fsel;
   logic                         bad_index;
   logic                         is_full;
   logic                         is_empty;
   logic [PTR_W-1:0]             head_cur;
   logic [PTR_W-1:0]             tail_cur;
   logic [PTR_W-1:0]             head_next;
   logic [PTR_W-1:0]             tail_next;
   logic [LOST_W-1:0]            lost_cur;
   logic [LOST_W-1:0]            lost_inc;
   logic [ADDR_W-1:0]            rd_addr;
   logic [ADDR_W-1:0]            wr_addr;
   logic                         do_read;
   logic                         do_write;
   logic [STATUS_W-1:0]          status_res_in;
   logic [LOST_W-1:0]            lost_res_in;

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= req_type;
         idx_ff  <= fifo_index;
         data_ff <= write_data;
      end
   end

   // Decode the addressed FIFO
   always_comb begin
      fsel      = idx_ff[IDX_W-1:0];
      bad_index = ({1'b0, idx_ff} >= (INDEX_W + 1)'(NUM_FIFOS));
      head_cur  = head_ff[fsel];
      tail_cur  = tail_ff[fsel];
      lost_cur  = lost_ff[fsel];
      is_full   = (fill_ff[fsel] == CNT_W'(FIFO_DEPTH));
      is_empty  = (fill_ff[fsel] == '0);
      head_next = (head_cur == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_cur + 1'b1;
      tail_next = (tail_cur == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_cur + 1'b1;
      lost_inc  = (lost_cur == LOST_MAX) ? lost_cur : lost_cur + 1'b1;
      rd_addr   = ADDR_W'(fsel) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(head_cur);
      wr_addr   = ADDR_W'(fsel) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(tail_cur);
      do_read   = !bad_index && (type_ff == REQ_READ) && !is_empty;
      do_write  = !bad_index && (type_ff == REQ_WRITE);
   end

   // Form the result fields
   always_comb begin
      status_res_in = ST_OK;
      lost_res_in   = lost_cur;
      if (bad_index) begin
         status_res_in = ST_BAD_INDEX;
         lost_res_in   = '0;
      end else begin
         case (type_ff)
            REQ_INIT: begin
               lost_res_in = '0;
            end
            REQ_READ: begin
               if (is_empty) begin
                  status_res_in = ST_EMPTY;
               end
            end
            REQ_WRITE: begin
               if (is_full) begin
                  status_res_in = ST_OVERWRITE;
                  lost_res_in   = lost_inc;
               end
            end
            default: begin
               status_res_in = ST_OK;
            end
         endcase
      end
   end

   // Advance pointers, counts and lost counters
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '{default: '0};
         tail_ff <= '{default: '0};
         fill_ff <= '{default: '0};
         lost_ff <= '{default: '0};
      end else if (cmd.execute && !bad_index) begin
         case (type_ff)
            REQ_INIT: begin
               head_ff[fsel] <= '0;
               tail_ff[fsel] <= '0;
               fill_ff[fsel] <= '0;
               lost_ff[fsel] <= '0;
            end
            REQ_READ: begin
               if (!is_empty) begin
                  head_ff[fsel] <= head_next;
                  fill_ff[fsel] <= fill_ff[fsel] - 1'b1;
               end
            end
            REQ_WRITE: begin
               tail_ff[fsel] <= tail_next;
               if (is_full) begin
                  head_ff[fsel] <= head_next;
                  lost_ff[fsel] <= lost_inc;
               end else begin
                  fill_ff[fsel] <= fill_ff[fsel] + 1'b1;
               end
            end
            default: begin
               fill_ff[fsel] <= fill_ff[fsel];
            end
         endcase
      end
   end

   // Memory write port
   always_ff @(posedge clock) begin
      if (cmd.execute && do_write) begin
         entry_store_ff[wr_addr] <= data_ff;
      end
   end

   // Memory read port, registered
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rdata_ff <= entry_store_ff[rd_addr];
      end
   end

   // Hold the pending result
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         read_ok_ff    <= do_read;
         status_res_ff <= status_res_in;
         lost_res_ff   <= lost_res_in;
      end
   end

   // Result register: load on reply, drop on a taken beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.reply) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reply) begin
         read_data_ff  <= read_ok_ff ? rdata_ff : '0;
         status_ff     <= status_res_ff;
         lost_count_ff <= lost_res_ff;
      end
   end

   assign dp_status.slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign read_data           = read_data_ff;
   assign status              = status_ff;
   assign lost_count          = lost_count_ff;

endmodule

[rtl/multi_ring_fifo_overwrite_unit.sv]
// Bank of NUM_FIFOS ring FIFOs of FIFO_DEPTH words, DATA_WIDTH bits each.
// req_chan carries one request per beat: req_type (init, read, write),
// fifo_index and write_data. rsp_chan returns one beat per request with
// read_data, status and the addressed FIFO's lost count.
// A write to a full FIFO overwrites the oldest word and bumps the
// saturating lost count; a read on an empty FIFO reports empty; an index
// at or above NUM_FIFOS reports a bad index and changes nothing.
// The request is registered, then the entry memory is accessed through
// its registered read port, then the result register is loaded. The block
// works on one request at a time: it takes no new request until the
// previous result has been loaded into the result register.
// A new request is taken while the previous result still waits in the
// result register; if the receiver stalls, the block holds the next
// result and stops taking requests until the register drains.
// Reset (synchronous) empties every FIFO and clears all lost counts;
// stored words need no clearing.
module multi_ring_fifo_overwrite_unit #(
   parameter int FIFO_DEPTH = 16,
   parameter int NUM_FIFOS  = 4,
   parameter int DATA_WIDTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   mrf_req_if.sink  req_chan,
   mrf_rsp_if.source rsp_chan
);
   import mrf_pkg::*;

   `include "assert_macros.svh"

   ctl_cmd_type   cmd;
   dp_status_type dp_status;
   logic          req_ready;

   mrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   mrf_datapath #(
      .FIFO_DEPTH (FIFO_DEPTH),
      .NUM_FIFOS  (NUM_FIFOS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .dp_status  (dp_status),
      .req_type   (req_chan.req_type),
      .fifo_index (req_chan.fifo_index),
      .write_data (req_chan.write_data),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .read_data  (rsp_chan.read_data),
      .status     (rsp_chan.status),
      .lost_count (rsp_chan.lost_count)
   );

   assign req_chan.ready = req_ready;

   // One request in flight: no new beat right after an accepted one
   `ASSERT_NEXT(a_one_in_flight, clock, reset,
      req_chan.valid && req_ready, !req_ready,
      "request accepted while another is in flight")

   // Controller commands never overlap
   `ASSERT_ALWAYS(a_cmd_onehot, clock, reset, $onehot0(cmd),
      "controller issued overlapping commands")

   // A reply never overwrites a result the receiver has not taken
   `ASSERT_IMPLIES(a_no_overrun, clock, reset, cmd.reply,
      !rsp_chan.valid || rsp_chan.ready, "result register overrun")

   // Failed reads and bad indexes return a zero word
   `ASSERT_IMPLIES(a_zero_data, clock, reset,
      rsp_chan.valid && (rsp_chan.status == ST_EMPTY || rsp_chan.status == ST_BAD_INDEX),
      rsp_chan.read_data == '0, "nonzero data on failed request")

endmodule
